// ===== design/ffa_pkg.sv =====
// package: shared types, constants and limits of the first-fit allocator
package ffa_pkg;

	localparam int GAP_SLOTS_DEF  = 32;
	localparam int LIVE_SLOTS_DEF = 32;
	localparam int WAIT_DEPTH_DEF = 32;

	localparam logic [24:0] MEM_MAX   = 25'd16777216;
	localparam logic [24:0] MEM_RESET = 25'd65536;

	localparam logic [2:0] KIND_GRANT  = 3'd0;
	localparam logic [2:0] KIND_QUEUED = 3'd1;
	localparam logic [2:0] KIND_WGRANT = 3'd2;
	localparam logic [2:0] KIND_STATUS = 3'd3;
	localparam logic [2:0] KIND_REJECT = 3'd4;

	localparam logic REQ_ARRIVAL = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [24:0] req_size;
		logic [31:0] hold_time;
	} ffa_in_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [23:0] base_address;
		logic [5:0]  waiting_count;
		logic [31:0] total_queued;
		logic [31:0] current_time;
		logic [31:0] last_event_time;
		logic        last_of_run;
	} ffa_out_t;

	// one free gap, base and length
	typedef struct packed {
		logic [24:0] base;
		logic [24:0] len;
	} ffa_gap_t;

	// command from the sequencer into the gap chain
	typedef struct packed {
		logic        clear;
		logic        shift;
		logic [24:0] base;
		logic [24:0] len;
	} ffa_gap_cmd_t;

endpackage

// ===== design/ffa_gap_cell.sv =====
// gap chain cell: holds one free gap and its valid bit, shifts on command
module ffa_gap_cell import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  logic     load_vld,
	input  ffa_gap_t load_gap,
	output logic     vld,
	output ffa_gap_t gap
);

	// valid bit resets, payload holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else if (load) begin
			vld <= load_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gap <= load_gap;
		end
	end

endmodule

// ===== design/first_fit_allocator_timed_release.sv =====
// first-fit allocator: gap cell chain, live table, wait fifo and sequencer
// an arrival runs one serial gap scan; a tick scans every live slot for expiry,
//   then runs one serial gap scan per waiting grant
// throughput: one item at a time; next item taken after the last result beat
// reset: asynchronous active low; one gap over 65536 units, tables empty
// a memory_size write restarts the allocator with the new size
module first_fit_allocator_timed_release import ffa_pkg::*; #(
	parameter int GAP_SLOTS  = GAP_SLOTS_DEF,
	parameter int LIVE_SLOTS = LIVE_SLOTS_DEF,
	parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [24:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  ffa_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output ffa_out_t    out_data
);

	localparam int LIVE_CAP = (LIVE_SLOTS < GAP_SLOTS) ? LIVE_SLOTS : GAP_SLOTS;
	localparam int GW = $clog2(GAP_SLOTS);
	localparam int LW = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;
	localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CW = $clog2(WAIT_DEPTH + 1);
	localparam int NW = $clog2(LIVE_SLOTS + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_FIT   = 4'd1;  // scan gaps for first fit
	localparam logic [3:0] ST_TAKE  = 4'd2;  // shrink or remove gap
	localparam logic [3:0] ST_REL   = 4'd3;  // scan live slots for expiry
	localparam logic [3:0] ST_RPOS  = 4'd4;  // find insert place in gaps
	localparam logic [3:0] ST_RUPD  = 4'd5;  // merge or insert
	localparam logic [3:0] ST_WHEAD = 4'd6;  // fetch wait head
	localparam logic [3:0] ST_OUT   = 4'd7;  // deliver a result beat
	localparam logic [3:0] ST_SHIFT = 4'd8;  // one step of a gap shift
	localparam logic [3:0] ST_INIT  = 4'd9;  // clear gaps and tables

	logic [3:0] st_q, ret_q;

	// gap chain storage
	logic     gvld [GAP_SLOTS];
	ffa_gap_t gap  [GAP_SLOTS];
	logic     gload [GAP_SLOTS];
	logic     gnvld [GAP_SLOTS];
	ffa_gap_t gnew  [GAP_SLOTS];

	// live table
	logic              lvld_q [LIVE_SLOTS];
	logic [24:0]       lbase_q [LIVE_SLOTS];
	logic [24:0]       lsize_q [LIVE_SLOTS];
	logic [31:0]       lend_q [LIVE_SLOTS];
	logic [NW-1:0]     lcnt_q;

	// wait fifo
	logic [24:0] wsize_q [WAIT_DEPTH];
	logic [31:0] whold_q [WAIT_DEPTH];
	logic [WW-1:0] whead_q;
	logic [CW-1:0] wcnt_q;

	logic [24:0] msize_q;
	logic [31:0] time_q, last_q, qtot_q;

	// working registers of the sequencer
	logic        waitmode_q;
	logic [24:0] sz_q;
	logic [31:0] hold_q;
	logic [GW:0] gi_q;      // gap scan index, also gap count bound
	logic [LW:0] li_q;
	logic [24:0] rbase_q, rsize_q;
	logic [GW:0] shf_from_q, shf_to_q;
	logic        shf_dir_q; // 1 open hole (right), 0 close hole (left)
	logic [GW:0] gcnt_q;
	ffa_out_t    res_q;     // next result beat, waits for the output register
	ffa_out_t    out_q;
	logic        outv_q;
	logic        shf_ins_q;

	genvar gv;
	generate
		for (gv = 0; gv < GAP_SLOTS; gv++) begin : g_cell
			ffa_gap_cell u_cell (
				.clk(clk), .arst_n(arst_n), .load(gload[gv]), .load_vld(gnvld[gv]),
				.load_gap(gnew[gv]), .vld(gvld[gv]), .gap(gap[gv])
			);
		end
	endgenerate

	logic [24:0] msz_c;
	always_comb begin
		msz_c = (cfg_data == 25'd0) ? 25'd1 : (cfg_data > MEM_MAX ? MEM_MAX : cfg_data);
	end

	wire cfg_wr = cfg_valid && cfg_ready;
	assign cfg_ready = (st_q == ST_IDLE) && !outv_q;
	assign in_stall  = !((st_q == ST_IDLE) && !outv_q) || cfg_valid;
	assign out_valid = outv_q;
	assign out_data  = out_q;
	wire in_acc  = in_valid && !in_stall;
	wire out_acc = outv_q && !out_stall;

	// gap at scan index
	logic [GW-1:0] gix;
	assign gix = gi_q[GW-1:0];
	logic     gcur_v;
	ffa_gap_t gcur;
	ffa_gap_t gprev;
	always_comb begin
		gcur_v = (gi_q < gcnt_q);
		gcur   = gap[gix];
		gprev  = gap[gix - GW'(1)];
	end

	// merge flags at the insert position
	logic mp_c, mn_c;

	// gap chain load control: neighbor hand-off for shifts, direct writes
	logic        gw_en;
	logic [GW-1:0] gw_ix;
	ffa_gap_t    gw_gap;
	logic        gw_vld;
	logic [GW:0] cur_sh;
	always_comb begin
		cur_sh = shf_from_q;
		for (int i = 0; i < GAP_SLOTS; i++) begin
			gload[i] = 1'b0;
			gnvld[i] = gvld[i];
			gnew[i]  = gap[i];
			if (st_q == ST_INIT) begin
				gload[i] = 1'b1;
				gnvld[i] = (i == 0);
				gnew[i]  = '{base: 25'd0, len: msize_q};
			end else if (st_q == ST_SHIFT && GW'(i) == cur_sh[GW-1:0]) begin
				gload[i] = 1'b1;
				if (shf_dir_q) begin
					gnvld[i] = 1'b1;
					gnew[i]  = (i > 0) ? gap[(i > 0) ? i-1 : 0] : gap[0];
				end else begin
					gnvld[i] = (i < GAP_SLOTS-1) ? gvld[(i < GAP_SLOTS-1) ? i+1 : i] : 1'b0;
					gnew[i]  = (i < GAP_SLOTS-1) ? gap[(i < GAP_SLOTS-1) ? i+1 : i] : gap[i];
				end
			end else if (gw_en && GW'(i) == gw_ix) begin
				gload[i] = 1'b1;
				gnvld[i] = gw_vld;
				gnew[i]  = gw_gap;
			end
		end
	end

	// wait fifo tail slot
	logic [31:0]   wsum_c;
	logic [WW-1:0] wtail_c;
	always_comb begin
		wsum_c  = 32'(whead_q) + 32'(wcnt_q);
		wtail_c = WW'((wsum_c >= 32'(WAIT_DEPTH)) ? wsum_c - 32'(WAIT_DEPTH) : wsum_c);
	end

	function automatic ffa_out_t mk(input logic [2:0] k, input logic [24:0] b,
			input logic [CW-1:0] wc, input logic [31:0] qt, input logic [31:0] tm,
			input logic [31:0] le, input logic lr);
		ffa_out_t o;
		o.result_kind     = k;
		o.base_address    = b[23:0];
		o.waiting_count   = 6'(wc);
		o.total_queued    = qt;
		o.current_time    = tm;
		o.last_event_time = le;
		o.last_of_run     = lr;
		return o;
	endfunction

	logic [LW-1:0] free_slot;
	logic          free_any;
	always_comb begin
		free_slot = '0;
		free_any  = 1'b0;
		for (int s = LIVE_SLOTS-1; s >= 0; s--) begin
			if (!lvld_q[s]) begin
				free_slot = LW'(s);
				free_any  = 1'b1;
			end
		end
	end

	logic [LW-1:0] lix;
	assign lix = li_q[LW-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT; ret_q <= ST_IDLE; outv_q <= 1'b0;
			msize_q <= MEM_RESET; lcnt_q <= '0; whead_q <= '0; wcnt_q <= '0;
			time_q <= '0; last_q <= '0; qtot_q <= '0; gcnt_q <= '0;
			for (int s = 0; s < LIVE_SLOTS; s++) lvld_q[s] <= 1'b0;
			waitmode_q <= 1'b0; gi_q <= '0; li_q <= '0;
			shf_from_q <= '0; shf_to_q <= '0; shf_dir_q <= 1'b0; shf_ins_q <= 1'b0;
		end else begin
			if (out_acc && st_q != ST_OUT) outv_q <= 1'b0;
			case (st_q)
				ST_INIT: begin
					gcnt_q <= (GW+1)'(1); lcnt_q <= '0; whead_q <= '0; wcnt_q <= '0;
					time_q <= '0; last_q <= '0; qtot_q <= '0;
					for (int s = 0; s < LIVE_SLOTS; s++) lvld_q[s] <= 1'b0;
					st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cfg_wr) begin
						msize_q <= msz_c;
						st_q <= ST_INIT;
					end else if (in_acc) begin
						sz_q <= in_data.req_size;
						hold_q <= (in_data.hold_time == 32'd0) ? 32'd1 : in_data.hold_time;
						waitmode_q <= 1'b0;
						gi_q <= '0;
						if (in_data.req_type == REQ_ARRIVAL) begin
							last_q <= time_q;
							if (in_data.req_size == 25'd0 || lcnt_q >= NW'(LIVE_CAP)) begin
								res_q <= mk(KIND_REJECT, '0, wcnt_q, qtot_q, time_q, time_q, 1'b1);
								st_q <= ST_OUT;
							end else begin
								st_q <= ST_FIT;
							end
						end else begin
							time_q <= time_q + 32'd1;
							li_q <= '0;
							st_q <= ST_REL;
						end
					end
				end
				ST_FIT: begin
					if (!gcur_v) begin
						// no fit
						if (waitmode_q) begin
							res_q <= mk(KIND_STATUS, '0, wcnt_q, qtot_q, time_q, last_q, 1'b1);
						end else if (wcnt_q < CW'(WAIT_DEPTH)) begin
							wsize_q[wtail_c] <= sz_q;
							whold_q[wtail_c] <= hold_q;
							wcnt_q <= wcnt_q + CW'(1);
							if (qtot_q != 32'hFFFFFFFF) qtot_q <= qtot_q + 32'd1;
							res_q <= mk(KIND_QUEUED, '0, wcnt_q + CW'(1),
								(qtot_q != 32'hFFFFFFFF) ? qtot_q + 32'd1 : qtot_q,
								time_q, last_q, 1'b1);
						end else begin
							res_q <= mk(KIND_REJECT, '0, wcnt_q, qtot_q, time_q, last_q, 1'b1);
						end
						st_q <= ST_OUT; ret_q <= ST_IDLE;
					end else if (gcur.len >= sz_q) begin
						st_q <= ST_TAKE;
					end else begin
						gi_q <= gi_q + (GW+1)'(1);
					end
				end
				ST_TAKE: begin
					rbase_q <= gcur.base;
					lvld_q[free_slot] <= 1'b1;
					lbase_q[free_slot] <= gcur.base;
					lsize_q[free_slot] <= sz_q;
					lend_q[free_slot] <= time_q + hold_q;
					lcnt_q <= lcnt_q + NW'(1);
					if (waitmode_q) begin
						whead_q <= (32'(whead_q) + 1 == WAIT_DEPTH) ? '0 : whead_q + WW'(1);
						wcnt_q <= wcnt_q - CW'(1);
						res_q <= mk(KIND_WGRANT, gcur.base, wcnt_q - CW'(1), qtot_q,
							time_q, last_q, 1'b0);
						ret_q <= ST_WHEAD;
					end else begin
						res_q <= mk(KIND_GRANT, gcur.base, wcnt_q, qtot_q, time_q, last_q, 1'b1);
						ret_q <= ST_IDLE;
					end
					if (gcur.len == sz_q) begin
						// remove gap: close hole leftward from gi
						gcnt_q <= gcnt_q - (GW+1)'(1);
						shf_dir_q <= 1'b0;
						shf_from_q <= gi_q;
						shf_to_q <= gcnt_q - (GW+1)'(1);
						shf_ins_q <= 1'b0;
						st_q <= ST_SHIFT;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_SHIFT: begin
					if (shf_dir_q) begin
						// moving right: from counts down to one above to
						shf_from_q <= shf_from_q - (GW+1)'(1);
						if (shf_from_q == shf_to_q + (GW+1)'(1)) st_q <= ST_RUPD;
					end else begin
						// moving left: from counts up to to
						shf_from_q <= shf_from_q + (GW+1)'(1);
						if (shf_from_q >= shf_to_q) st_q <= (ret_q == ST_REL) ? ST_REL : ST_OUT;
					end
				end
				ST_OUT: begin
					if (!outv_q || out_acc) begin
						out_q <= res_q;
						outv_q <= 1'b1;
						st_q <= ret_q;
						gi_q <= '0;
						waitmode_q <= 1'b1;
					end
				end
				ST_WHEAD: begin
					gi_q <= '0;
					if (wcnt_q == '0 || lcnt_q >= NW'(LIVE_CAP)) begin
						res_q <= mk(KIND_STATUS, '0, wcnt_q, qtot_q, time_q, last_q, 1'b1);
						ret_q <= ST_IDLE;
						st_q <= ST_OUT;
					end else begin
						sz_q <= wsize_q[whead_q];
						hold_q <= whold_q[whead_q];
						waitmode_q <= 1'b1;
						st_q <= ST_FIT;
					end
				end
				ST_REL: begin
					if (li_q == (LW+1)'(LIVE_SLOTS)) begin
						st_q <= ST_WHEAD;
					end else if (lvld_q[lix] && lend_q[lix] == time_q) begin
						lvld_q[lix] <= 1'b0;
						lcnt_q <= lcnt_q - NW'(1);
						last_q <= time_q;
						rbase_q <= lbase_q[lix];
						rsize_q <= lsize_q[lix];
						gi_q <= '0;
						st_q <= ST_RPOS;
					end else begin
						li_q <= li_q + (LW+1)'(1);
					end
				end
				ST_RPOS: begin
					if (gcur_v && gcur.base <= rbase_q) begin
						gi_q <= gi_q + (GW+1)'(1);
					end else begin
						st_q <= ST_RUPD;
						shf_ins_q <= 1'b0;
					end
				end
				ST_RUPD: begin
					ret_q <= ST_REL;
					if (mp_c && mn_c) begin
						li_q <= li_q + (LW+1)'(1);
						gcnt_q <= gcnt_q - (GW+1)'(1);
						shf_dir_q <= 1'b0;
						shf_from_q <= gi_q;
						shf_to_q <= gcnt_q - (GW+1)'(1);
						st_q <= ST_SHIFT;
					end else if (!mp_c && !mn_c && !shf_ins_q && gcnt_q < (GW+1)'(GAP_SLOTS)) begin
						// open hole at gi by shifting right, then revisit
						gcnt_q <= gcnt_q + (GW+1)'(1);
						shf_dir_q <= 1'b1;
						shf_from_q <= gcnt_q;
						shf_to_q <= gi_q;
						shf_ins_q <= 1'b1;
						st_q <= (gcnt_q == gi_q) ? ST_RUPD : ST_SHIFT;
					end else begin
						li_q <= li_q + (LW+1)'(1);
						shf_ins_q <= 1'b0;
						st_q <= ST_REL;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// merge flags at the insert position
	always_comb begin
		mp_c = !shf_ins_q && (gi_q != '0) && (gprev.base + gprev.len == rbase_q);
		mn_c = !shf_ins_q && gcur_v && (rbase_q + rsize_q == gcur.base);
	end

	// direct gap writes
	always_comb begin
		gw_en = 1'b0; gw_ix = gix; gw_gap = gcur; gw_vld = 1'b1;
		if (st_q == ST_TAKE && gcur.len != sz_q) begin
			gw_en = 1'b1;
			gw_gap = '{base: gcur.base + sz_q, len: gcur.len - sz_q};
		end else if (st_q == ST_RUPD) begin
			if (mp_c) begin
				gw_en = 1'b1; gw_ix = gix - GW'(1);
				gw_gap = '{base: gprev.base,
					len: gprev.len + rsize_q + (mn_c ? gcur.len : 25'd0)};
			end else if (mn_c) begin
				gw_en = 1'b1;
				gw_gap = '{base: rbase_q, len: gcur.len + rsize_q};
			end else if (shf_ins_q) begin
				gw_en = 1'b1;
				gw_gap = '{base: rbase_q, len: rsize_q};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		outv_q && out_stall |=> outv_q && $stable(out_q))
		else $error("stalled result beat changed");
	assert property (@(posedge clk) disable iff (!arst_n) lcnt_q <= NW'(LIVE_CAP))
		else $error("live count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n) wcnt_q <= CW'(WAIT_DEPTH))
		else $error("wait count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) gcnt_q <= (GW+1)'(GAP_SLOTS))
		else $error("gap count above slots");

endmodule
